/* rtl/core/abks_pkg.sv */
// ----------------------------------------------------------------------------
// abks_pkg
// Types and codes shared by the array-backed key set and its users.
// ----------------------------------------------------------------------------
package abks_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_REMOVE     = 3'd1;
   localparam logic [2:0] MODE_REMOVE_ANY = 3'd2;
   localparam logic [2:0] MODE_FIND       = 3'd3;
   localparam logic [2:0] MODE_CLEAR      = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_PRESENT   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [5:0]         position;
      logic signed [31:0] key_out;
      logic [6:0]         count;
   } rsp_type;

endpackage

/* rtl/core/abks_ram.sv */
// ----------------------------------------------------------------------------
// abks_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abks_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/array_backed_key_set.sv */
// ----------------------------------------------------------------------------
// array_backed_key_set
// Fixed-capacity set of signed keys held densely in insertion order in a RAM,
// searched linearly from entry zero, compacted on removal.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start high and busy low
//   result    rsp_strobe, rsp_item       valid for exactly one cycle
//
// Clear, unused codes and operations on an empty set are answered from idle.
// A search issues one RAM read per cycle; a removal then moves held - at - 1
// entries at one per cycle, bounded by the single read port of the entry RAM.
// Remove-any reads the last entry while idle and answers from the pop state.
// Synchronous reset empties the set at once; the RAM is not cleared.
// The result side cannot stall; busy is high until the result is shown.
// ----------------------------------------------------------------------------
module array_backed_key_set #(
   parameter int CAPACITY = abks_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  abks_pkg::req_type req_item,
   output logic              rsp_strobe,
   output abks_pkg::rsp_type rsp_item
);

   import abks_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_POP
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] held_ff, held_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          strobe_ff, strobe_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [IW-1:0] chk_ff, chk_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] src_ff, src_in;
   logic [IW-1:0] wr_ff, wr_in;
   logic          wv_ff, wv_in;

   logic          ram_we;
   logic [IW-1:0] ram_wa;
   logic [31:0]   ram_wd;
   logic [IW-1:0] ram_ra;
   logic [31:0]   ram_rdata;

   abks_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_wa),
      .wdata(ram_wd),
      .raddr(ram_ra),
      .rdata(ram_rdata)
   );

   always_comb begin
      logic        issue;
      logic [31:0] pos_wide;
      logic [31:0] held_wide;
      state_in   = state_ff;
      held_in    = held_ff;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      rd_in      = rd_ff;
      chk_in     = chk_ff;
      chk_vld_in = 1'b0;
      src_in     = src_ff;
      wr_in      = wr_ff;
      wv_in      = 1'b0;
      ram_we     = 1'b0;
      ram_wa     = '0;
      ram_wd     = req_ff.key;
      ram_ra     = '0;
      issue      = 1'b0;
      pos_wide   = '0;
      unique case (state_ff)
         S_IDLE: begin
            ram_ra = IW'(held_ff - 1'b1);
            if (start) begin
               req_in          = req_item;
               rd_in           = '0;
               rsp_in.status   = ST_OK;
               rsp_in.position = '0;
               rsp_in.key_out  = req_item.key;
               case (req_item.mode)
                  MODE_INSERT: begin
                     if (held_ff == '0) begin
                        ram_we    = 1'b1;
                        ram_wa    = '0;
                        ram_wd    = req_item.key;
                        held_in   = CW'(1);
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  MODE_REMOVE: begin
                     if (held_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        strobe_in     = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  MODE_FIND: begin
                     if (held_ff == '0) begin
                        rsp_in.status = ST_NOT_FOUND;
                        strobe_in     = 1'b1;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  MODE_REMOVE_ANY: begin
                     if (held_ff == '0) begin
                        rsp_in.status  = ST_EMPTY;
                        rsp_in.key_out = '0;
                        strobe_in      = 1'b1;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  MODE_CLEAR: begin
                     held_in   = '0;
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            issue  = rd_ff < held_ff;
            ram_ra = IW'(rd_ff);
            if (issue) begin
               rd_in      = rd_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_in     = IW'(rd_ff);
            end
            if (chk_vld_ff && ram_rdata == req_ff.key) begin
               chk_vld_in      = 1'b0;
               pos_wide        = 32'(chk_ff);
               rsp_in.position = pos_wide[5:0];
               case (req_ff.mode)
                  MODE_INSERT: begin
                     rsp_in.status = ST_PRESENT;
                     strobe_in     = 1'b1;
                     state_in      = S_IDLE;
                  end
                  MODE_REMOVE: begin
                     src_in   = CW'(chk_ff) + 1'b1;
                     state_in = S_SHIFT;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end
               endcase
            end else if (chk_vld_ff && (CW'(chk_ff) + 1'b1) == held_ff) begin
               chk_vld_in = 1'b0;
               strobe_in  = 1'b1;
               state_in   = S_IDLE;
               if (req_ff.mode == MODE_INSERT) begin
                  if (held_ff >= CW'(CAPACITY)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wa          = IW'(held_ff);
                     ram_wd          = req_ff.key;
                     held_in         = held_ff + 1'b1;
                     pos_wide        = 32'(held_ff);
                     rsp_in.position = pos_wide[5:0];
                  end
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
         end
         S_SHIFT: begin
            issue  = src_ff < held_ff;
            ram_ra = IW'(src_ff);
            if (issue) begin
               src_in = src_ff + 1'b1;
               wv_in  = 1'b1;
               wr_in  = IW'(src_ff - 1'b1);
            end
            if (wv_ff) begin
               ram_we = 1'b1;
               ram_wa = wr_ff;
               ram_wd = ram_rdata;
            end
            if (!issue) begin
               held_in   = held_ff - 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_POP: begin
            held_in         = held_ff - 1'b1;
            pos_wide        = 32'(held_in);
            rsp_in.position = pos_wide[5:0];
            rsp_in.key_out  = ram_rdata;
            strobe_in       = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      held_wide = 32'(held_in);
      if (strobe_in) begin
         rsp_in.count = held_wide[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         held_ff    <= '0;
         strobe_ff  <= 1'b0;
         chk_vld_ff <= 1'b0;
         wv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         strobe_ff  <= strobe_in;
         chk_vld_ff <= chk_vld_in;
         wv_ff      <= wv_in;
         req_ff     <= req_in;
         rsp_ff     <= rsp_in;
         rd_ff      <= rd_in;
         chk_ff     <= chk_in;
         src_ff     <= src_in;
         wr_ff      <= wr_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_held_bounded: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(CAPACITY))
      else $error("held count exceeds capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted item neither in progress nor answered");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && ram_we) |-> ((CW'(ram_wa) + 1'b1) < held_ff))
      else $error("compaction writes outside the held entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_FULL) |-> (held_ff == CW'(CAPACITY)))
      else $error("full reported while the set has room");

endmodule

/* test/tb_array_backed_key_set.sv */
// ----------------------------------------------------------------------------
// tb_array_backed_key_set
// Self-checking regression for the array-backed key set. A short table of
// directed items covers the empty set, the extreme keys, every operation and
// the unused codes. Bursts of random items then fill the set to capacity,
// churn it with mixed traffic, drain it and throw noise at it. Every result is
// compared field by field with its typed table row or the bench's shadow set.
// ----------------------------------------------------------------------------
module tb_array_backed_key_set;

   import abks_pkg::*;

   localparam int CAPACITY      = DEFAULT_CAPACITY;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic TYPED    = 1'b1;
   localparam logic BY_MODEL = 1'b0;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type outcome;
   } stim_row_type;

   typedef enum {STYLE_FILL, STYLE_MIXED, STYLE_DRAIN, STYLE_NOISE} burst_style_type;

   localparam rsp_type NO_OUTCOME = '0;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   logic signed [31:0] shadow_keys [CAPACITY];
   int                 shadow_held = 0;

   stim_row_type       queued_rows [$];
   rsp_type            awaited_results [$];
   logic signed [31:0] recent_keys [$];

   int  mismatches = 0;
   int  results_checked = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   int  status_tally [8];
   bit  tight = 1'b0;

   array_backed_key_set #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type apply_to_shadow_set(req_type r);
      rsp_type o;
      int      at;
      int      i;
      o.status   = ST_OK;
      o.position = '0;
      o.key_out  = r.key;
      at = -1;
      for (i = 0; i < shadow_held; i++) begin
         if (shadow_keys[i] == r.key) begin
            at = i;
            break;
         end
      end
      case (r.mode)
         MODE_INSERT: begin
            if (at >= 0) begin
               o.status   = ST_PRESENT;
               o.position = 6'(at);
            end else if (shadow_held >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               shadow_keys[shadow_held] = r.key;
               o.position = 6'(shadow_held);
               shadow_held++;
            end
         end
         MODE_REMOVE: begin
            if (shadow_held == 0) begin
               o.status = ST_EMPTY;
            end else if (at >= 0) begin
               for (i = at; i + 1 < shadow_held; i++) shadow_keys[i] = shadow_keys[i + 1];
               shadow_held--;
               o.position = 6'(at);
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
         MODE_REMOVE_ANY: begin
            if (shadow_held == 0) begin
               o.status  = ST_EMPTY;
               o.key_out = '0;
            end else begin
               shadow_held--;
               o.position = 6'(shadow_held);
               o.key_out  = shadow_keys[shadow_held];
            end
         end
         MODE_FIND: begin
            if (at >= 0) o.position = 6'(at);
            else o.status = ST_NOT_FOUND;
         end
         MODE_CLEAR: begin
            shadow_held = 0;
         end
         default: begin
         end
      endcase
      o.count = 7'(shadow_held);
      return o;
   endfunction

   // Items are taken and results checked in one place, so that an item and a
   // result falling on the same edge are always handled in the same order.
   always @(posedge clock) begin : watch
      stim_row_type row;
      rsp_type      predicted;
      rsp_type      want;
      if (!reset) begin
         if (start && !busy) begin
            row = queued_rows.pop_front();
            predicted = apply_to_shadow_set(req_item);
            awaited_results.push_back(row.typed ? row.outcome : predicted);
         end
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               $error("result with nothing awaited: status %0d position %0d key_out %0d",
                      rsp_item.status, rsp_item.position, rsp_item.key_out);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               status_tally[want.status]++;
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  mismatches++;
               end
               if (rsp_item.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_item.position);
                  mismatches++;
               end
               if (rsp_item.key_out !== want.key_out) begin
                  $error("key_out: expected %0d, got %0d", want.key_out, rsp_item.key_out);
                  mismatches++;
               end
               if (rsp_item.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_item.count);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("array_backed_key_set regression: fail");
         $finish;
      end
   end

   function automatic stim_row_type directed_row(int n);
      case (n)
         0:  return {MODE_REMOVE_ANY, 32'sh0000_1234, TYPED, ST_EMPTY, 6'd0, 32'sh0, 7'd0};
         1:  return {MODE_REMOVE, 32'sd5, TYPED, ST_EMPTY, 6'd0, 32'sd5, 7'd0};
         2:  return {MODE_FIND, 32'sd0, TYPED, ST_NOT_FOUND, 6'd0, 32'sd0, 7'd0};
         3:  return {MODE_INSERT, 32'sh8000_0000, TYPED, ST_OK, 6'd0, 32'sh8000_0000, 7'd1};
         4:  return {MODE_INSERT, 32'sh7FFF_FFFF, TYPED, ST_OK, 6'd1, 32'sh7FFF_FFFF, 7'd2};
         5:  return {MODE_INSERT, 32'shFFFF_FFFF, TYPED, ST_OK, 6'd2, 32'shFFFF_FFFF, 7'd3};
         6:  return {MODE_INSERT, 32'sd0, TYPED, ST_OK, 6'd3, 32'sd0, 7'd4};
         7:  return {MODE_INSERT, 32'sh7FFF_FFFF, TYPED, ST_PRESENT, 6'd1, 32'sh7FFF_FFFF, 7'd4};
         8:  return {MODE_FIND, 32'shFFFF_FFFF, TYPED, ST_OK, 6'd2, 32'shFFFF_FFFF, 7'd4};
         9:  return {MODE_FIND, 32'sd12345, TYPED, ST_NOT_FOUND, 6'd0, 32'sd12345, 7'd4};
         10: return {MODE_REMOVE, 32'sd777, TYPED, ST_NOT_FOUND, 6'd0, 32'sd777, 7'd4};
         11: return {MODE_REMOVE, 32'sh8000_0000, TYPED, ST_OK, 6'd0, 32'sh8000_0000, 7'd3};
         12: return {MODE_FIND, 32'sd0, TYPED, ST_OK, 6'd2, 32'sd0, 7'd3};
         13: return {3'd5, 32'sh5A5A_5A5A, TYPED, ST_OK, 6'd0, 32'sh5A5A_5A5A, 7'd3};
         14: return {3'd6, 32'shA5A5_A5A5, BY_MODEL, NO_OUTCOME};
         15: return {3'd7, 32'shFFFF_FFFF, TYPED, ST_OK, 6'd0, 32'shFFFF_FFFF, 7'd3};
         16: return {MODE_INSERT, 32'sh5555_5555, BY_MODEL, NO_OUTCOME};
         17: return {MODE_REMOVE, 32'shFFFF_FFFF, BY_MODEL, NO_OUTCOME};
         18: return {MODE_REMOVE_ANY, 32'sh0000_DEAD, BY_MODEL, NO_OUTCOME};
         19: return {MODE_CLEAR, 32'sd42, TYPED, ST_OK, 6'd0, 32'sd42, 7'd0};
         20: return {MODE_REMOVE_ANY, 32'sd9, TYPED, ST_EMPTY, 6'd0, 32'sd0, 7'd0};
         21: return {MODE_INSERT, 32'sh8000_0000, TYPED, ST_OK, 6'd0, 32'sh8000_0000, 7'd1};
         22: return {MODE_FIND, 32'sh7FFF_FFFF, TYPED, ST_NOT_FOUND, 6'd0, 32'sh7FFF_FFFF, 7'd1};
         23: return {MODE_REMOVE, 32'sh8000_0000, TYPED, ST_OK, 6'd0, 32'sh8000_0000, 7'd0};
         default: return {MODE_REMOVE, 32'sd0, TYPED, ST_EMPTY, 6'd0, 32'sd0, 7'd0};
      endcase
   endfunction

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (tight || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [31:0] known_key();
      if (recent_keys.size() == 0) return $urandom;
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
   endfunction

   function automatic req_type next_request(burst_style_type style);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.key = $urandom;
      case (style)
         STYLE_FILL: begin
            r.mode = MODE_INSERT;
            if (roll >= 85) r.key = known_key();
         end
         STYLE_MIXED: begin
            if (roll < 35) begin
               r.mode = MODE_INSERT;
               if (roll < 15) r.key = known_key();
            end else if (roll < 60) begin
               r.mode = MODE_REMOVE;
               if (roll < 54) r.key = known_key();
            end else if (roll < 70) begin
               r.mode = MODE_REMOVE_ANY;
            end else if (roll < 93) begin
               r.mode = MODE_FIND;
               if (roll < 87) r.key = known_key();
            end else if (roll < 96) begin
               r.mode = MODE_CLEAR;
            end else begin
               r.mode = 3'($urandom_range(5, 7));
            end
         end
         STYLE_DRAIN: begin
            if (roll < 50) begin
               r.mode = MODE_REMOVE;
               r.key  = known_key();
            end else if (roll < 90) begin
               r.mode = MODE_REMOVE_ANY;
            end else begin
               r.mode = MODE_FIND;
               r.key  = known_key();
            end
         end
         default: begin
            r.mode = 3'($urandom_range(0, 7));
            if (roll < 40) r.key = $urandom_range(0, 7);
         end
      endcase
      if (r.mode == MODE_INSERT) begin
         recent_keys.push_back(r.key);
         if (recent_keys.size() > CAPACITY) void'(recent_keys.pop_front());
      end
      return r;
   endfunction

   task automatic offer(input stim_row_type row);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      queued_rows.push_back(row);
      start    <= 1'b1;
      req_item <= row.item;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   initial begin
      burst_style_type style;
      stim_row_type    row;
      int              n;
      int              roll;
      int              burst_len;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) offer(directed_row(n));

      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 25) style = STYLE_FILL;
         else if (roll < 65) style = STYLE_MIXED;
         else if (roll < 85) style = STYLE_DRAIN;
         else style = STYLE_NOISE;
         burst_len = (style == STYLE_FILL) ? $urandom_range(70, 100) : $urandom_range(15, 60);
         tight = ($urandom_range(0, 4) == 0);
         repeat (burst_len) begin
            row.item    = next_request(style);
            row.typed   = BY_MODEL;
            row.outcome = NO_OUTCOME;
            offer(row);
         end
      end

      start <= 1'b0;
      while (queued_rows.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         mismatches++;
      end

      $display("%0d items sent and %0d results checked in %0d cycles",
               items_sent, results_checked, cycle_count);
      $display("outcomes: ok %0d, not found %0d, already present %0d, full %0d, empty %0d",
               status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_PRESENT],
               status_tally[ST_FULL], status_tally[ST_EMPTY]);
      if (mismatches == 0) begin
         $display("array_backed_key_set regression: pass");
      end else begin
         $display("array_backed_key_set regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/abks_pkg.sv
rtl/core/abks_ram.sv
rtl/core/array_backed_key_set.sv
test/tb_array_backed_key_set.sv
